FILE: sv/hics_pkg.sv
package hics_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = 8;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;
endpackage

FILE: sv/hics_div.sv
module hics_div
  import hics_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  div_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot
);
  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_r[31:0], q_r[63]};
    trial = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd64;
        q_r <= req.num;
        den_r <= req.den;
        rem_r <= '0;
      end else if (busy_r) begin
        // restoring step: one quotient bit per cycle
        if (!trial[32]) begin
          rem_r <= trial;
          q_r <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
endmodule

FILE: sv/histogram_inverse_cdf_sampler.sv
// Piecewise-linear inverse-CDF sampler.
// Input channel (in_valid/in_ready) carries one beat per item: a load
// (in_req_type = 0) writes entry in_entry_index, if nonzero, of the x and
// y tables; a sample (in_req_type = 1) draws one result from in_uniform.
// Result channel (out_valid/out_ready) carries sample_x and flat_bin, one
// beat per sample item; loads give no result.
// Config channel (cfg_valid/cfg_ready) writes table_count, always ready.
// A load is taken while idle, without leaving that state. A sample does a
// binary search over the two table memories, whose reads are registered:
// a top bound read and check, then per halving step (up to 8 steps) a
// middle read and check and another top bound read and check; then the
// chosen bin pair is read, a multiply, a divider start, the bit-serial
// divider run and taking its quotient, and the step into the output
// register. A flat bin skips the multiply and divide.
// One item is in work at a time. The result sits in an output register;
// the next item is accepted while it waits, but its own result holds the
// block until the receiver takes the earlier beat.
// After reset table_count is 1, out_valid is low and entry zero reads as
// (0,0); other entries are undefined until loaded. No clearing pass.
module histogram_inverse_cdf_sampler
  import hics_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_entry_index,
  input  logic [31:0] in_entry_x,
  input  logic [31:0] in_entry_y,
  input  logic [30:0] in_uniform,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample_x,
  output logic        out_flat_bin,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_table_count
);
  typedef enum logic [3:0] {
    S_IDLE, S_TOPRD, S_TOPCHK, S_MIDRD, S_MIDCHK,
    S_RD0, S_RD1, S_CAP1, S_MUL, S_DIV, S_WAITDIV, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] xmem [TABLE_DEPTH];
  logic [31:0] ymem [TABLE_DEPTH];
  logic [31:0] xrd_r, yrd_r;
  logic [AW-1:0] raddr;
  logic        rzero_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] lo_r, hi_r, mid_r;
  logic [30:0] u_r;
  logic [31:0] x0_r, y0_r, dx_r, du_r, dy_r;
  logic [63:0] prod_r;
  logic [31:0] res_r;
  logic        flat_r, ovalid_r, div_start;
  logic        div_busy, div_done;
  logic [63:0] quot;
  div_req_t    dreq;
  logic [AW-1:0] top;
  logic [31:0] xv, yv;
  logic [32:0] sum;

  always_comb begin
    if (count_r == '0) top = AW'(1);
    else if (32'(count_r) > TABLE_DEPTH - 1) top = AW'(TABLE_DEPTH - 1);
    else top = AW'(count_r);
  end

  // entry zero always reads as zero
  assign xv = rzero_r ? 32'd0 : xrd_r;
  assign yv = rzero_r ? 32'd0 : yrd_r;

  always_comb begin
    unique case (state_r)
      S_IDLE:  raddr = top;
      S_TOPRD: raddr = hi_r;
      S_MIDRD: raddr = mid_r;
      S_RD1:   raddr = lo_r + AW'(1);
      default: raddr = lo_r;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_req_type == REQ_LOAD &&
        in_entry_index != 8'd0 && 32'(in_entry_index) < TABLE_DEPTH) begin
      xmem[AW'(in_entry_index)] <= in_entry_x;
      ymem[AW'(in_entry_index)] <= in_entry_y;
    end
    xrd_r <= xmem[raddr];
    yrd_r <= ymem[raddr];
    rzero_r <= (raddr == '0);
  end

  assign dreq.num = prod_r;
  assign dreq.den = dy_r;
  assign div_start = (state_r == S_DIV);

  hics_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .req(dreq),
    .busy(div_busy), .done(div_done), .quot(quot)
  );

  assign sum = {1'b0, x0_r} + {1'b0, quot[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid) count_r <= cfg_table_count;
      unique case (state_r)
        S_IDLE: if (in_valid && in_req_type == REQ_SAMPLE) begin
          u_r <= in_uniform;
          lo_r <= '0;
          hi_r <= top;
          state_r <= S_TOPRD;
        end
        S_TOPRD: state_r <= S_TOPCHK;
        S_TOPCHK: begin
          if ({1'b0, u_r} == yv) begin
            lo_r <= hi_r - AW'(1);
            state_r <= S_RD0;
          end else if (hi_r > lo_r + AW'(1)) begin
            mid_r <= AW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
            state_r <= S_MIDRD;
          end else begin
            state_r <= S_RD0;
          end
        end
        S_MIDRD: state_r <= S_MIDCHK;
        S_MIDCHK: begin
          if ({1'b0, u_r} >= yv) lo_r <= mid_r;
          else hi_r <= mid_r;
          state_r <= S_TOPRD;
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          x0_r <= xv;
          y0_r <= yv;
          state_r <= S_CAP1;
        end
        S_CAP1: begin
          if (yv <= y0_r) begin
            res_r <= x0_r;
            flat_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            dy_r <= yv - y0_r;
            dx_r <= (xv > x0_r) ? xv - x0_r : 32'd0;
            du_r <= ({1'b0, u_r} > y0_r) ? {1'b0, u_r} - y0_r : 32'd0;
            flat_r <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= 64'(dx_r) * 64'(du_r);
          state_r <= S_DIV;
        end
        S_DIV: state_r <= S_WAITDIV;
        S_WAITDIV: if (div_done) begin
          res_r <= (quot[63:32] != '0 || sum[32]) ? 32'hFFFF_FFFF : sum[31:0];
          state_r <= S_OUT;
        end
        S_OUT: if (!ovalid_r || out_ready) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_OUT && (!ovalid_r || out_ready)) begin
        ovalid_r <= 1'b1;
        out_sample_x <= res_r;
        out_flat_bin <= flat_r;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid = ovalid_r;

  a_lo_below_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIDCHK) |-> (lo_r < mid_r && mid_r < hi_r))
    else $error("search bounds out of order");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !div_busy)
    else $error("divider busy at start");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_sample_x))
    else $error("result beat dropped");
endmodule
